FILE: rtl/core/tldls_pkg.sv
package tldls_pkg;

  localparam int LINE_BYTES_DEF = 48;

  // configuration port
  localparam int CFG_W = 9;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_MAX_BLACK   = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_INVERT      = 2'd2;

  localparam logic [8:0] MAX_BLACK_RST   = 9'd64;
  localparam logic [8:0] IMAGE_WIDTH_RST = 9'd384;
  localparam logic [8:0] MIN_LIMIT       = 9'd8;

  // result item kinds
  localparam logic ITEM_PRINT = 1'b0;
  localparam logic ITEM_MOTOR = 1'b1;

  localparam logic [63:0] MOTOR_STEPS = 64'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_BYTE_END,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_MOTOR
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic bit_adv;
    logic clear_pass;
    logic word_rst;
    logic word_adv;
    logic rd;
    logic out_word;
    logic out_motor;
    logic commit;
    logic line_wrap;
  } cmd_t;

  typedef struct packed {
    logic trig;
    logic bit_last;
    logic word_last;
    logic pos_last;
    logic count_nz;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/core/dot_in_if.sv
interface dot_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] dot_byte;

  modport source (output valid, output dot_byte, input ready);
  modport sink (input valid, input dot_byte, output ready);
endinterface

FILE: rtl/core/print_out_if.sv
interface print_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [63:0] payload_word;
  logic [2:0]  word_index;
  logic        last_of_run;

  modport source (
    output valid, output item_kind, output payload_word, output word_index,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input item_kind, input payload_word, input word_index,
    input last_of_run, output ready
  );
endinterface

FILE: rtl/core/tldls_ctrl.sv
module tldls_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tldls_pkg::stat_t stat,
  output tldls_pkg::cmd_t  cmd
);
  import tldls_pkg::*;

  state_t state, state_next;
  logic   line_end, line_end_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      line_end <= 1'b0;
    end else begin
      state    <= state_next;
      line_end <= line_end_next;
    end
  end

  always_comb begin
    state_next    = state;
    line_end_next = line_end;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_BIT;
      end
      S_BIT: begin
        if (stat.trig) begin
          state_next    = S_EMIT_RD;
          line_end_next = 1'b0;
        end else if (stat.bit_last) begin
          state_next = S_BYTE_END;
        end
      end
      S_BYTE_END: begin
        if (stat.pos_last) begin
          if (stat.count_nz) begin
            state_next    = S_EMIT_RD;
            line_end_next = 1'b1;
          end else begin
            state_next = S_MOTOR;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_RD: state_next = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (stat.out_free) begin
          if (!stat.word_last) state_next = S_EMIT_RD;
          else if (line_end) state_next = S_MOTOR;
          else if (stat.bit_last) state_next = S_BYTE_END;
          else state_next = S_BIT;
        end
      end
      S_MOTOR: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        // no transaction is taken while reset is held
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      S_BIT: begin
        cmd.step = 1'b1;
        if (stat.trig) cmd.word_rst = 1'b1;
        else if (!stat.bit_last) cmd.bit_adv = 1'b1;
      end
      S_BYTE_END: begin
        if (stat.pos_last) cmd.word_rst = stat.count_nz;
        else cmd.commit = 1'b1;
      end
      S_EMIT_RD: cmd.rd = 1'b1;
      S_EMIT_OUT: begin
        if (stat.out_free) begin
          cmd.out_word = 1'b1;
          if (!stat.word_last) begin
            cmd.word_adv = 1'b1;
          end else if (!line_end) begin
            // mid-line pass done: restart the pass, carry on with the next dot or finish the byte
            cmd.clear_pass = 1'b1;
            cmd.bit_adv    = !stat.bit_last;
          end
        end
      end
      S_MOTOR: begin
        if (stat.out_free) begin
          cmd.out_motor  = 1'b1;
          cmd.clear_pass = 1'b1;
          cmd.line_wrap  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_word_rst_on_emit: assert property (@(posedge clk) disable iff (rst)
    (state_next == S_EMIT_RD && state != S_EMIT_RD && state != S_EMIT_OUT) |-> cmd.word_rst)
    else $error("pass emission entered without word restart");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_ready && state != S_IDLE) |-> 1'b0)
    else $error("input taken while an item is in progress");

  a_motor_after_line: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_OUT && stat.out_free && stat.word_last && line_end) |=> state == S_MOTOR)
    else $error("line-end pass not followed by motor step");

endmodule

FILE: rtl/core/tldls_dp.sv
module tldls_dp #(
  parameter int LINE_BYTES = tldls_pkg::LINE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [7:0]                    dot_byte,
  input  logic                          cfg_wr_en,
  input  logic [tldls_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tldls_pkg::CFG_W-1:0]   cfg_data,
  input  tldls_pkg::cmd_t               cmd,
  output tldls_pkg::stat_t              stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [63:0]                   out_payload,
  output logic [2:0]                    out_index,
  output logic                          out_last
);
  import tldls_pkg::*;

  localparam int WORDS = (LINE_BYTES + 7) / 8;
  localparam int POS_W = $clog2(LINE_BYTES);
  localparam int WI_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int DI_W  = (POS_W + 3 > 9) ? POS_W + 3 : 9;
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(LINE_BYTES - 1);
  localparam logic [WI_W-1:0]  WORD_LAST = WI_W'(WORDS - 1);

  // configuration
  logic [8:0] max_black;
  logic [8:0] image_width;
  logic       invert_dots;

  // per-byte and pass state
  logic [7:0]             byte_reg;
  logic [2:0]             bit_idx;
  logic [7:0]             cur;
  logic [8:0]             count;
  logic [POS_W-1:0]       pos;
  logic [WI_W-1:0]        widx;
  logic [WORDS-1:0][7:0]  valid;
  logic [63:0]            mem [WORDS];
  logic [63:0]            rd_data;

  logic [8:0]      limit;
  logic [8:0]      count_inc;
  logic            in_width;
  logic            dot;
  logic            hit;
  logic [WI_W-1:0] pos_word;
  logic [2:0]      pos_lane;
  logic [63:0]     word;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_black   <= MAX_BLACK_RST;
      image_width <= IMAGE_WIDTH_RST;
      invert_dots <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAX_BLACK:   max_black   <= cfg_data;
        REG_IMAGE_WIDTH: image_width <= cfg_data;
        REG_INVERT:      invert_dots <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign limit     = (max_black < MIN_LIMIT) ? MIN_LIMIT : max_black;
  assign count_inc = count + 9'd1;
  assign in_width  = DI_W'({pos, bit_idx}) < DI_W'(image_width);
  assign dot       = byte_reg[~bit_idx] ^ invert_dots;
  assign hit       = in_width && dot;
  assign pos_word  = WI_W'(pos >> 3);
  assign pos_lane  = pos[2:0];

  assign stat.trig      = hit && (count_inc >= limit);
  assign stat.bit_last  = bit_idx == 3'd7;
  assign stat.word_last = widx == WORD_LAST;
  assign stat.pos_last  = pos == POS_LAST;
  assign stat.count_nz  = count != '0;
  assign stat.out_free  = !out_valid || out_ready;

  // lane 0 is the leftmost byte; the byte in progress has not been committed yet
  always_comb begin
    for (int l = 0; l < 8; l++) begin
      word[63-8*l -: 8] = valid[widx][l] ? rd_data[63-8*l -: 8] : 8'h00;
      if (widx == pos_word && pos_lane == 3'(l)) word[63-8*l -: 8] = word[63-8*l -: 8] | cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) byte_reg <= dot_byte;
    if (cmd.rd) rd_data <= mem[widx];
    if (cmd.commit) mem[pos_word][{~pos_lane, 3'b000} +: 8] <= cur;
    if (cmd.out_word) begin
      out_kind    <= ITEM_PRINT;
      out_payload <= word;
      out_index   <= 3'(widx);
      out_last    <= stat.word_last;
    end else if (cmd.out_motor) begin
      out_kind    <= ITEM_MOTOR;
      out_payload <= MOTOR_STEPS;
      out_index   <= 3'd0;
      out_last    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_idx   <= '0;
      cur       <= '0;
      count     <= '0;
      pos       <= '0;
      widx      <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) bit_idx <= '0;
      else if (cmd.bit_adv) bit_idx <= bit_idx + 3'd1;

      if (cmd.word_rst) widx <= '0;
      else if (cmd.word_adv) widx <= widx + WI_W'(1);

      if (cmd.clear_pass) begin
        cur   <= '0;
        count <= '0;
        valid <= '0;
      end else begin
        if (cmd.step && hit) begin
          cur[~bit_idx] <= 1'b1;
          count         <= count_inc;
        end
        if (cmd.commit) begin
          valid[pos_word][pos_lane] <= 1'b1;
          cur                       <= '0;
        end
      end

      if (cmd.line_wrap) pos <= '0;
      else if (cmd.commit) pos <= pos + POS_W'(1);

      if (cmd.out_word || cmd.out_motor) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_line_wrap_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.out_motor |=> (pos == '0) && (count == '0) && (cur == '0) && (valid == '0))
    else $error("pass state not cleared at line end");

  a_motor_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == ITEM_MOTOR) |->
      (out_last && out_payload == MOTOR_STEPS && out_index == 3'd0))
    else $error("malformed motor item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_word || cmd.out_motor) |-> (!out_valid || out_ready))
    else $error("output register overwritten while held");

endmodule

FILE: rtl/core/thermal_line_dot_limit_splitter_core.sv
// Each byte: an accept step, its dots one per cycle in S_BIT while no pass goes out,
// then a commit, except for the last byte of a line.
// A pass reads the buffer, then loads the output, for each 64-dot word.
// The line end adds a motor item; output stalls hold the pass and the motor item.
// A result is registered and is on the output in the cycle after it is formed.
// Synchronous reset: registers to 64/384/0, count and position to zero, buffer emptied.
module thermal_line_dot_limit_splitter_core #(
  parameter int LINE_BYTES = tldls_pkg::LINE_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tldls_pkg::IDX_W-1:0] cfg_index,
  input  logic [tldls_pkg::CFG_W-1:0] cfg_data,
  dot_in_if.sink                      dots,
  print_out_if.source                 items
);
  import tldls_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tldls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dots.valid),
    .in_ready (dots.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tldls_dp #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .dot_byte    (dots.dot_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (items.ready),
    .out_valid   (items.valid),
    .out_kind    (items.item_kind),
    .out_payload (items.payload_word),
    .out_index   (items.word_index),
    .out_last    (items.last_of_run)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import tldls_pkg::*;

  localparam int LINE_BYTES     = LINE_BYTES_DEF;
  localparam int WORDS_PER_PASS = (LINE_BYTES + 7) / 8;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int PHASES         = 7;

  // index 3 is not decoded by the block
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic        item_kind;
    logic [63:0] payload_word;
    logic [2:0]  word_index;
    logic        last_of_run;
  } print_item_t;

  // Tracks line position, pass buffer and black count; queues the print words
  // and motor steps that each accepted byte should produce.
  class print_pass_tracker;
    logic [8:0]  max_black;
    logic [8:0]  img_width;
    logic        inv_dots;
    logic [7:0]  pass_buf [LINE_BYTES];
    logic [8:0]  black_cnt;
    int unsigned line_pos;
    print_item_t expected_items [$];
    int          mismatch_count;

    function new();
      max_black      = MAX_BLACK_RST;
      img_width      = IMAGE_WIDTH_RST;
      inv_dots       = 1'b0;
      black_cnt      = '0;
      line_pos       = 0;
      mismatch_count = 0;
      clear_pass();
    endfunction

    function void clear_pass();
      foreach (pass_buf[i]) pass_buf[i] = 8'h00;
      black_cnt = '0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_MAX_BLACK:   max_black = data;
        REG_IMAGE_WIDTH: img_width = data;
        REG_INVERT:      inv_dots  = data[0];
        default: ;
      endcase
    endfunction

    function void queue_pass();
      print_item_t it;
      logic [63:0] word;
      int unsigned p;
      for (int w = 0; w < WORDS_PER_PASS; w++) begin
        word = '0;
        for (int b = 0; b < 8; b++) begin
          p = w * 8 + b;
          word = {word[55:0], (p < LINE_BYTES) ? pass_buf[p] : 8'h00};
        end
        it.item_kind    = ITEM_PRINT;
        it.payload_word = word;
        it.word_index   = w[2:0];
        it.last_of_run  = (w == WORDS_PER_PASS - 1);
        expected_items.push_back(it);
      end
    endfunction

    function void take_byte(logic [7:0] dots);
      int unsigned limit;
      int unsigned dot_idx;
      logic        dot;
      print_item_t step;
      bit          past_width;
      limit = 32'((max_black < MIN_LIMIT) ? MIN_LIMIT : max_black);
      past_width = 1'b0;
      for (int i = 0; i < 8; i++) begin
        dot_idx = line_pos * 8 + i;
        if (dot_idx >= 32'(img_width)) past_width = 1'b1;
        if (!past_width) begin
          dot = dots[7-i] ^ inv_dots;
          if (dot) begin
            pass_buf[line_pos][7-i] = 1'b1;
            black_cnt = black_cnt + 9'd1;
            if (32'(black_cnt) >= limit) begin
              queue_pass();
              clear_pass();
            end
          end
        end
      end
      line_pos++;
      if (line_pos >= LINE_BYTES) begin
        if (black_cnt != 0) queue_pass();
        step.item_kind    = ITEM_MOTOR;
        step.payload_word = MOTOR_STEPS;
        step.word_index   = 3'd0;
        step.last_of_run  = 1'b1;
        expected_items.push_back(step);
        clear_pass();
        line_pos = 0;
      end
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatch_count++;
    endtask

    task check_item(print_item_t got);
      print_item_t want;
      if (expected_items.size() == 0) begin
        flag_mismatch($sformatf("unexpected item kind=%0d payload=%h idx=%0d last=%0d",
                                got.item_kind, got.payload_word, got.word_index,
                                got.last_of_run));
        return;
      end
      want = expected_items.pop_front();
      if (got.item_kind !== want.item_kind)
        flag_mismatch($sformatf("item_kind %0d, expected %0d",
                                got.item_kind, want.item_kind));
      if (got.payload_word !== want.payload_word)
        flag_mismatch($sformatf("payload_word %h, expected %h",
                                got.payload_word, want.payload_word));
      if (got.word_index !== want.word_index)
        flag_mismatch($sformatf("word_index %0d, expected %0d",
                                got.word_index, want.word_index));
      if (got.last_of_run !== want.last_of_run)
        flag_mismatch($sformatf("last_of_run %0d, expected %0d",
                                got.last_of_run, want.last_of_run));
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dot_in_if    dots_ch();
  print_out_if items_ch();

  thermal_line_dot_limit_splitter_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dots      (dots_ch),
    .items     (items_ch)
  );

  print_pass_tracker tracker;
  bit                hold_req;
  int                burst_left;
  longint            cycle_count;
  print_item_t       seen_item;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // output side: random stall segments, plus one long hold-off on request
  initial begin
    int seg_left;
    int mode;
    int tick;
    int hold_left;
    seg_left  = 0;
    mode      = 0;
    tick      = 0;
    hold_left = 0;
    items_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        items_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 2);
          seg_left = $urandom_range(10, 60);
        end
        seg_left--;
        tick++;
        case (mode)
          0:       items_ch.ready <= 1'b1;
          1:       items_ch.ready <= 1'($urandom_range(0, 1));
          default: items_ch.ready <= (tick % 4 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && items_ch.valid && items_ch.ready) begin
      seen_item.item_kind    = items_ch.item_kind;
      seen_item.payload_word = items_ch.payload_word;
      seen_item.word_index   = items_ch.word_index;
      seen_item.last_of_run  = items_ch.last_of_run;
      tracker.check_item(seen_item);
    end
  end

  task automatic send_byte(input logic [7:0] b, input int gap);
    if (gap > 0) begin
      dots_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    dots_ch.valid    <= 1'b1;
    dots_ch.dot_byte <= b;
    @(posedge clk);
    while (!dots_ch.ready) @(posedge clk);
    tracker.take_byte(b);
  endtask

  // bursts of back-to-back transactions separated by random gaps
  task automatic send_in_bursts(input logic [7:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send_byte(b, gap);
  endtask

  task automatic stop_sending();
    dots_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (tracker.expected_items.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic set_line_config(input logic [8:0] max_black, input logic [8:0] width,
                                 input logic inv);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    put_reg(REG_MAX_BLACK, max_black);
    put_reg(REG_IMAGE_WIDTH, width);
    put_reg(REG_INVERT, {junk, inv});
    put_reg(REG_SPARE, CFG_W'($urandom_range(0, 511)));
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [8:0]  ph_max   [PHASES];
    logic [8:0]  ph_width [PHASES];
    logic        ph_inv   [PHASES];
    int          ph_len   [PHASES];
    logic [7:0]  edge_bytes [5];
    ph_max   = '{9'd5,   9'd511, 9'd0, 9'd384, 9'd100, 9'd8,   9'd64};
    ph_width = '{9'd200, 9'd511, 9'd0, 9'd384, 9'd13,  9'd384, 9'd384};
    ph_inv   = '{1'b1,   1'b0,   1'b1, 1'b1,   1'b0,   1'b0,   1'b0};
    ph_len   = '{30,     30,     25,   30,     30,     25,     25};
    edge_bytes = '{8'h00, 8'h80, 8'h01, 8'h55, 8'hAA};

    tracker     = new();
    hold_req    = 1'b0;
    burst_left  = 0;
    cycle_count = 0;
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    dots_ch.valid    <= 1'b0;
    dots_ch.dot_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset limit of 64: eight full bytes trigger one pass
    repeat (8) send_byte(8'hFF, 0);
    foreach (edge_bytes[i]) send_byte(edge_bytes[i], 0);

    // lowest limit, every full byte makes a pass; output held off meanwhile
    stop_sending();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    set_line_config(9'd8, 9'd384, 1'b0);
    hold_req = 1'b1;
    repeat (12) send_byte(8'hFF, 0);

    for (int p = 0; p < PHASES; p++) begin
      stop_sending();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      set_line_config(ph_max[p], ph_width[p], ph_inv[p]);
      for (int i = 0; i < ph_len[p]; i++) begin
        if (i == ph_len[p] / 2) begin
          stop_sending();
          wait_drained();
        end
        send_in_bursts(pick_byte());
      end
    end

    stop_sending();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.expected_items.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
